// ----- rtl/ita_pkg.sv -----
// Shared constants, types and helper functions for the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package ita_pkg;

  // Operand and field sizing
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned MAX_WIDTH   = 63;
  localparam int unsigned WIDTH_W     = 6;

  // Digit storage: enough BCD digits for decimal, enough nibbles for hex
  localparam int unsigned DEC_DIGITS  = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned HEX_DIGITS  = (VALUE_BITS + 3) / 4;
  localparam int unsigned NUM_DIGITS  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int unsigned DIG_W       = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W       = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BIT_CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CMP_W       = ((WIDTH_W > CNT_W) ? WIDTH_W : CNT_W) + 1;

  // ASCII codes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // Conversion kinds
  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEXL = 2'd2,
    CMD_HEXU = 2'd3
  } cmd_e;

  // One nibble to its ASCII digit
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      ch = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
    end else begin
      ch = CHAR_LOWER_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/ita_req_if.sv -----
// Request and result channel interfaces of the integer-to-ASCII formatter.
`timescale 1ns / 1ps

interface ita_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  command;
  logic [5:0]  field_width;
  logic        zero_pad;

  modport source (output valid, value, command, field_width, zero_pad, input ready);
  modport sink   (input valid, value, command, field_width, zero_pad, output ready);
endinterface

interface ita_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ----- rtl/ita_dabble_unit.sv -----
// Shift-and-add-3 step: one binary bit into the BCD digit register.
`timescale 1ns / 1ps

module ita_dabble_unit (
  input  logic [ita_pkg::DIG_W-1:0] bcd_i,
  input  logic                      bit_i,
  output logic [ita_pkg::DIG_W-1:0] bcd_o
);

  logic [ita_pkg::DIG_W-1:0] adj;

  // add 3 to every digit of 5 or more, all digits side by side
  for (genvar g = 0; g < ita_pkg::NUM_DIGITS; g++) begin : g_adj
    assign adj[4*g +: 4] = (bcd_i[4*g +: 4] >= 4'd5) ? (bcd_i[4*g +: 4] + 4'd3)
                                                      : bcd_i[4*g +: 4];
  end

  // shift the next binary bit in at the bottom
  assign bcd_o = {adj[ita_pkg::DIG_W-2:0], bit_i};

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// Integer-to-ASCII formatter: accepts one request at a time and emits one character per cycle while the sink is ready.
// Decimal: accept, shift-add-3 conversion of all VALUE_BITS (32) bits, then normalize.
// Hex: accept, then normalize (drop leading zero digits one at a time, then size the pad).
// Then one character per cycle while the sink is ready; up to 63 characters.
// A new request is taken in the cycle after the last character is delivered.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; a request in progress is dropped.
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
  input  logic            clk_i,
  input  logic            rst_ni,
  ita_req_if.sink         req_i,
  ita_rsp_if.source       rsp_o
);

  localparam int unsigned VB  = ita_pkg::VALUE_BITS;
  localparam int unsigned DW  = ita_pkg::DIG_W;
  localparam int unsigned CW  = ita_pkg::CNT_W;
  localparam int unsigned BCW = ita_pkg::BIT_CNT_W;
  localparam int unsigned WW  = ita_pkg::WIDTH_W;
  localparam int unsigned MW  = ita_pkg::CMP_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [VB-1:0]   bin_q, bin_d;
  logic [DW-1:0]   dig_q, dig_d;
  logic [BCW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [CW-1:0]   nd_q, nd_d;
  logic [WW-1:0]   pad_q, pad_d;
  logic [WW-1:0]   width_q, width_d;
  logic            sign_q, sign_d;
  logic            zpad_q, zpad_d;
  logic            upper_q, upper_d;

  ita_pkg::cmd_e   cmd;
  logic [VB-1:0]   mag;
  logic [VB-1:0]   mag_abs;
  logic            neg_in;
  logic            is_hex;
  logic [DW-1:0]   dabble_out;
  logic [3:0]      top_nib;
  logic [MW-1:0]   len;
  logic [7:0]      emit_char;
  logic            emit_last;
  logic            req_fire;
  logic            rsp_fire;

  // request decode
  assign cmd     = ita_pkg::cmd_e'(req_i.command);
  assign mag     = VB'(req_i.value);
  assign neg_in  = (cmd == ita_pkg::CMD_SDEC) && mag[VB-1];
  assign mag_abs = neg_in ? VB'(~mag + VB'(1)) : mag;
  assign is_hex  = (cmd == ita_pkg::CMD_HEXL) || (cmd == ita_pkg::CMD_HEXU);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  // single binary-to-BCD step
  ita_dabble_unit u_dabble (
    .bcd_i (dig_q),
    .bit_i (bin_q[VB-1]),
    .bcd_o (dabble_out)
  );

  assign top_nib = dig_q[DW-1 -: 4];
  assign len     = MW'(nd_q) + MW'(sign_q);

  // character selection: space pad, sign, zero pad, digits
  always_comb begin
    if (zpad_q) begin
      if (sign_q) begin
        emit_char = ita_pkg::CHAR_MINUS;
      end else if (pad_q != '0) begin
        emit_char = ita_pkg::CHAR_ZERO;
      end else begin
        emit_char = ita_pkg::digit_char(top_nib, upper_q);
      end
    end else begin
      if (pad_q != '0) begin
        emit_char = ita_pkg::CHAR_SPACE;
      end else if (sign_q) begin
        emit_char = ita_pkg::CHAR_MINUS;
      end else begin
        emit_char = ita_pkg::digit_char(top_nib, upper_q);
      end
    end
  end

  assign emit_last = (pad_q == '0) && !sign_q && (nd_q == CW'(1));

  assign rsp_o.valid     = (state_q == ST_EMIT);
  assign rsp_o.out_char  = emit_char;
  assign rsp_o.last_char = emit_last;

  // sequencer
  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    dig_d     = dig_q;
    bit_cnt_d = bit_cnt_q;
    nd_d      = nd_q;
    pad_d     = pad_q;
    width_d   = width_q;
    sign_d    = sign_q;
    zpad_d    = zpad_q;
    upper_d   = upper_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          bin_d     = mag_abs;
          sign_d    = neg_in;
          zpad_d    = req_i.zero_pad;
          upper_d   = (cmd == ita_pkg::CMD_HEXU);
          width_d   = (req_i.field_width > WW'(ita_pkg::MAX_WIDTH)) ?
                      WW'(ita_pkg::MAX_WIDTH) : req_i.field_width;
          nd_d      = CW'(ita_pkg::NUM_DIGITS);
          bit_cnt_d = BCW'(VB - 1);
          if (is_hex) begin
            dig_d   = DW'(mag);
            state_d = ST_NORM;
          end else begin
            dig_d   = '0;
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_d = dabble_out;
        bin_d = bin_q << 1;
        if (bit_cnt_q == '0) begin
          state_d = ST_NORM;
        end else begin
          bit_cnt_d = bit_cnt_q - BCW'(1);
        end
      end
      ST_NORM: begin
        // drop leading zero digits, keeping at least one
        if ((nd_q > CW'(1)) && (top_nib == 4'd0)) begin
          dig_d = dig_q << 4;
          nd_d  = nd_q - CW'(1);
        end else begin
          pad_d   = (MW'(width_q) > len) ? WW'(MW'(width_q) - len) : '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rsp_fire) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (zpad_q) begin
            if (sign_q) begin
              sign_d = 1'b0;
            end else if (pad_q != '0) begin
              pad_d = pad_q - WW'(1);
            end else begin
              dig_d = dig_q << 4;
              nd_d  = nd_q - CW'(1);
            end
          end else begin
            if (pad_q != '0) begin
              pad_d = pad_q - WW'(1);
            end else if (sign_q) begin
              sign_d = 1'b0;
            end else begin
              dig_d = dig_q << 4;
              nd_d  = nd_q - CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    dig_q     <= dig_d;
    bit_cnt_q <= bit_cnt_d;
    nd_q      <= nd_d;
    pad_q     <= pad_d;
    width_q   <= width_d;
    sign_q    <= sign_d;
    zpad_q    <= zpad_d;
    upper_q   <= upper_d;
  end

endmodule

// ----- tb/integer_to_ascii_formatter_tb.sv -----
// Self-checking testbench for the integer-to-ASCII formatter: directed table, then random requests.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

  localparam int unsigned RAND_REQS   = 190;
  localparam int unsigned CALM_REQS   = 30;    // final stretch with no idling
  localparam int unsigned LONG_HOLD   = 300;   // receiver back-pressure, in cycles
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 4000;

  // one expected character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  // one directed request; empty text means the formatter model decides
  typedef struct {
    logic [31:0]   value;
    ita_pkg::cmd_e cmd;
    logic [5:0]    width;
    logic          zpad;
    string         text;
  } fmt_case_t;

  logic clk_i;
  logic rst_ni;

  ita_req_if req_if ();
  ita_rsp_if rsp_if ();

  char_t       pending_chars [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_left    = 0;
  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;

  integer_to_ascii_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Formatter model: queue the characters one request produces
  function automatic void format_integer(input logic [31:0] value, input ita_pkg::cmd_e cmd,
                                         input logic [5:0] width, input logic zpad);
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] d;
    logic        neg;
    logic [7:0]  digs [$];
    logic [7:0]  line [$];
    int unsigned fw;
    int unsigned len;
    int unsigned pad;
    mag  = value;
    neg  = 1'b0;
    base = (cmd == ita_pkg::CMD_HEXL || cmd == ita_pkg::CMD_HEXU) ? 32'd16 : 32'd10;
    fw   = (width > ita_pkg::MAX_WIDTH) ? ita_pkg::MAX_WIDTH : width;
    // signed decimal only: two's complement magnitude, most negative included
    if (cmd == ita_pkg::CMD_SDEC && value[ita_pkg::VALUE_BITS-1]) begin
      neg = 1'b1;
      mag = ~value + 32'd1;
    end
    // digits, most significant first; zero still gives one digit
    do begin
      d = mag % base;
      if (d < 32'd10) begin
        digs.push_front(ita_pkg::CHAR_ZERO + d[7:0]);
      end else if (cmd == ita_pkg::CMD_HEXU) begin
        digs.push_front(ita_pkg::CHAR_UPPER_A + d[7:0] - 8'd10);
      end else begin
        digs.push_front(ita_pkg::CHAR_LOWER_A + d[7:0] - 8'd10);
      end
      mag = mag / base;
    end while (mag != 32'd0);
    len = digs.size() + (neg ? 1 : 0);
    pad = (fw > len) ? fw - len : 0;
    // spaces go ahead of the sign, zeros after it
    if (!zpad) repeat (pad) line.push_back(ita_pkg::CHAR_SPACE);
    if (neg) line.push_back(ita_pkg::CHAR_MINUS);
    if (zpad) repeat (pad) line.push_back(ita_pkg::CHAR_ZERO);
    foreach (digs[i]) line.push_back(digs[i]);
    foreach (line[i]) pending_chars.push_back('{line[i], i == line.size() - 1});
  endfunction

  function automatic void expect_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{text[i], i == text.len() - 1});
    end
  endfunction

  // Offer one request, optionally after an idle burst; queue its characters once taken
  task automatic send_req(input logic [31:0] value, input ita_pkg::cmd_e cmd,
                          input logic [5:0] width, input logic zpad, input string text);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.value       <= value;
    req_if.command     <= cmd;
    req_if.field_width <= width;
    req_if.zero_pad    <= zpad;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    if (text.len() != 0) begin
      expect_text(text);
    end else begin
      format_integer(value, cmd, width, zpad);
    end
  endtask

  // Random request: mostly short widths, values spread over magnitudes and signs
  task automatic send_random();
    logic [31:0] v;
    logic [5:0]  w;
    int unsigned sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: v = $urandom();
      1: v = $urandom_range(0, 999);
      2: v = 32'd0 - 32'($urandom_range(1, 99999));
      3: v = 32'd1 << $urandom_range(0, 31);
      4: v = (32'd1 << $urandom_range(0, 31)) - 32'd1;
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    sel = $urandom_range(0, 19);
    if (sel < 17) begin
      w = 6'($urandom_range(0, 12));
    end else if (sel < 19) begin
      w = 6'($urandom_range(13, 24));
    end else begin
      w = 6'($urandom_range(25, 63));
    end
    send_req(v, ita_pkg::cmd_e'($urandom_range(0, 3)), w, 1'($urandom_range(0, 1)), "");
  endtask

  // Drop valid and hold until every queued character has come out
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and end of run
  initial begin
    fmt_case_t fixed_cases [24];
    fixed_cases = '{
      '{32'h0000_0000, ita_pkg::CMD_UDEC, 6'd0,  1'b0, "0"},
      '{32'h0000_0000, ita_pkg::CMD_SDEC, 6'd0,  1'b1, "0"},
      '{32'h0000_0000, ita_pkg::CMD_HEXL, 6'd1,  1'b0, "0"},
      '{32'h8000_0000, ita_pkg::CMD_SDEC, 6'd0,  1'b0, "-2147483648"},
      '{32'h7FFF_FFFF, ita_pkg::CMD_SDEC, 6'd0,  1'b1, "2147483647"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_UDEC, 6'd0,  1'b0, "4294967295"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_SDEC, 6'd0,  1'b0, "-1"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_HEXL, 6'd0,  1'b0, "ffffffff"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_HEXU, 6'd0,  1'b1, "FFFFFFFF"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_SDEC, 6'd5,  1'b0, "   -1"},
      '{32'hFFFF_FFFF, ita_pkg::CMD_SDEC, 6'd5,  1'b1, "-0001"},
      '{32'hFFFF_FF85, ita_pkg::CMD_SDEC, 6'd6,  1'b1, "-00123"},
      '{32'h0000_002A, ita_pkg::CMD_UDEC, 6'd6,  1'b1, "000042"},
      '{32'h0000_ABCD, ita_pkg::CMD_HEXU, 6'd8,  1'b0, "    ABCD"},
      '{32'h0000_ABCD, ita_pkg::CMD_HEXL, 6'd8,  1'b1, "0000abcd"},
      // bit 15 set is not a sign
      '{32'h0000_8000, ita_pkg::CMD_SDEC, 6'd0,  1'b0, "32768"},
      // hex ignores the sign; width shorter than the digits cuts nothing
      '{32'h8000_0000, ita_pkg::CMD_HEXL, 6'd3,  1'b0, "80000000"},
      '{32'h8000_0000, ita_pkg::CMD_UDEC, 6'd2,  1'b1, "2147483648"},
      '{32'h1234_5678, ita_pkg::CMD_UDEC, 6'd11, 1'b0, "  305419896"},
      '{32'h0000_0005, ita_pkg::CMD_SDEC, 6'd1,  1'b1, "5"},
      '{32'h0000_0000, ita_pkg::CMD_UDEC, 6'd63, 1'b0, ""},
      '{32'h8000_0000, ita_pkg::CMD_SDEC, 6'd63, 1'b1, ""},
      '{32'hDEAD_BEEF, ita_pkg::CMD_HEXU, 6'd63, 1'b0, ""},
      '{32'h5555_5555, ita_pkg::CMD_HEXL, 6'd42, 1'b1, ""}
    };
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.value       = '0;
    req_if.command     = ita_pkg::CMD_SDEC;
    req_if.field_width = '0;
    req_if.zero_pad    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (fixed_cases[i]) begin
      send_req(fixed_cases[i].value, fixed_cases[i].cmd, fixed_cases[i].width,
               fixed_cases[i].zpad, fixed_cases[i].text);
    end

    for (int i = 0; i < RAND_REQS; i++) begin
      idle_on = !(i >= 60 && i < 80) && (i < RAND_REQS - CALM_REQS);
      // long receiver hold while requests keep coming
      if (i == 30) long_hold_req = 1'b1;
      // sender pause until the formatter is empty
      if (i == 110) wait_drained();
      send_random();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: check each character, then pick next cycle's ready
  initial begin
    char_t exp_char;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_chars.size() == 0) begin
          $error("out_char: expected none, got 0x%02h", rsp_if.out_char);
          mismatch_cnt++;
        end else begin
          exp_char = pending_chars.pop_front();
          if (rsp_if.out_char !== exp_char.ch) begin
            $error("out_char: expected 0x%02h, got 0x%02h", exp_char.ch, rsp_if.out_char);
            mismatch_cnt++;
          end
          if (rsp_if.last_char !== exp_char.last) begin
            $error("last_char: expected %0b, got %0b", exp_char.last, rsp_if.last_char);
            mismatch_cnt++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles with no request or character moving
  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
